@@ rtl/imusfp_pkg.sv @@
// shared types, constants and scaling helpers for the imu serial frame parser
`default_nettype none
package imusfp_pkg;

   localparam int unsigned MaxBurstBytes = 33;
   localparam int unsigned FrameLen      = 11;
   localparam int unsigned StoredBytes   = FrameLen - 1;
   localparam int unsigned QueueDepth    = 2;

   localparam logic [7:0] HdrByte   = 8'h55;
   localparam logic [7:0] TypeAcc   = 8'h51;
   localparam logic [7:0] TypeRate  = 8'h52;
   localparam logic [7:0] TypeAngle = 8'h53;

   localparam logic [1:0] KindAcc   = 2'd0;
   localparam logic [1:0] KindRate  = 2'd1;
   localparam logic [1:0] KindAngle = 2'd2;

   localparam int unsigned ProdWidth  = 24;
   localparam int unsigned ValueWidth = 19;

   // one checked frame waiting for scaling
   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_z;
      logic signed [15:0] aux;
   } frame_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic logic signed [7:0] mul_factor(input logic [1:0] kind);
      logic signed [7:0] f;
      unique case (kind)
         KindAcc:   f = 8'sd125;
         KindRate:  f = 8'sd125;
         KindAngle: f = 8'sd45;
         default:   f = 8'sd0;
      endcase
      return f;
   endfunction

   // divide by a power of two, truncating toward zero
   function automatic logic signed [ValueWidth-1:0] scale_down(
      input logic signed [ProdWidth-1:0] p,
      input logic [1:0]                  kind
   );
      logic [3:0]                  sh;
      logic signed [ProdWidth-1:0] bias;
      logic signed [ProdWidth-1:0] biased;
      logic signed [ProdWidth-1:0] shifted;
      unique case (kind)
         KindAcc:   sh = 4'd4;
         KindRate:  sh = 4'd7;
         KindAngle: sh = 4'd9;
         default:   sh = 4'd0;
      endcase
      bias    = p[ProdWidth-1] ? ((ProdWidth'(1) <<< sh) - ProdWidth'(1)) : '0;
      biased  = p + bias;
      shifted = biased >>> sh;
      return shifted[ValueWidth-1:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/imusfp_front.sv @@
// byte intake: burst tracking, frame alignment, checksum and type check
`default_nettype none
module imusfp_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [7:0]            req_rx_byte,
   input  wire logic                  req_burst_start,
   input  wire imusfp_pkg::queue_stat_type q_stat,
   output      logic                  push,
   output      imusfp_pkg::frame_type push_frame
);

   logic [7:0] bytes_ff [imusfp_pkg::StoredBytes];
   logic [3:0] pos_ff, pos_in, pos_eff;
   logic [5:0] cnt_ff, cnt_in, cnt_eff;
   logic [7:0] sum_ff, sum_in, sum_eff;
   logic       take, counted, last_byte, type_ok;
   logic [1:0] kind;

   assign req_ready = !q_stat.full;
   assign take      = req_valid && req_ready;

   always_comb begin
      pos_eff   = req_burst_start ? '0 : pos_ff;
      cnt_eff   = req_burst_start ? '0 : cnt_ff;
      sum_eff   = req_burst_start ? '0 : sum_ff;
      counted   = cnt_eff < 6'(imusfp_pkg::MaxBurstBytes);
      last_byte = pos_eff == 4'(imusfp_pkg::StoredBytes);
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      sum_in    = sum_ff;
      if (take) begin
         pos_in = pos_eff;
         cnt_in = cnt_eff;
         sum_in = sum_eff;
         if (counted) begin
            cnt_in = cnt_eff + 6'd1;
            if (last_byte) begin
               pos_in = '0;
               sum_in = '0;
            end else begin
               pos_in = pos_eff + 4'd1;
               sum_in = sum_eff + req_rx_byte;
            end
         end
      end
   end

   always_comb begin
      type_ok = 1'b1;
      kind    = imusfp_pkg::KindAcc;
      unique case (bytes_ff[1])
         imusfp_pkg::TypeAcc:   kind = imusfp_pkg::KindAcc;
         imusfp_pkg::TypeRate:  kind = imusfp_pkg::KindRate;
         imusfp_pkg::TypeAngle: kind = imusfp_pkg::KindAngle;
         default:               type_ok = 1'b0;
      endcase
   end

   assign push = take && counted && last_byte && type_ok
              && bytes_ff[0] == imusfp_pkg::HdrByte && sum_eff == req_rx_byte;

   always_comb begin
      push_frame.kind  = kind;
      push_frame.raw_x = {bytes_ff[3], bytes_ff[2]};
      push_frame.raw_y = {bytes_ff[5], bytes_ff[4]};
      push_frame.raw_z = {bytes_ff[7], bytes_ff[6]};
      push_frame.aux   = (kind == imusfp_pkg::KindRate) ? '0 : {bytes_ff[9], bytes_ff[8]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         cnt_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < imusfp_pkg::StoredBytes; i++) begin
         if (take && counted && pos_eff == 4'(i)) begin
            bytes_ff[i] <= req_rx_byte;
         end
      end
   end

endmodule
`default_nettype wire

@@ rtl/imusfp_queue.sv @@
// two-entry frame queue between intake and scaling
`default_nettype none
module imusfp_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire imusfp_pkg::queue_ctl_type ctl,
   input  wire imusfp_pkg::frame_type     wr_frame,
   output      imusfp_pkg::frame_type     rd_frame,
   output      imusfp_pkg::queue_stat_type stat
);

   imusfp_pkg::frame_type mem_ff [imusfp_pkg::QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign stat.full  = count_ff == 2'(imusfp_pkg::QueueDepth);
   assign stat.empty = count_ff == 2'd0;
   assign do_push    = ctl.push && !stat.full;
   assign do_pop     = ctl.pop && !stat.empty;
   assign rd_frame   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_frame;
      end
   end

endmodule
`default_nettype wire

@@ rtl/imusfp_back.sv @@
// scaling pipeline: constant multiply, then truncating shift into the result register
`default_nettype none
module imusfp_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire imusfp_pkg::queue_stat_type q_stat,
   input  wire imusfp_pkg::frame_type      q_frame,
   output      logic                       pop,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic [1:0]                 rsp_frame_kind,
   output      logic signed [18:0]         rsp_value_x,
   output      logic signed [18:0]         rsp_value_y,
   output      logic signed [18:0]         rsp_value_z,
   output      logic signed [15:0]         rsp_aux_word
);

   logic                                   s1_valid_ff;
   logic [1:0]                             s1_kind_ff;
   logic signed [imusfp_pkg::ProdWidth-1:0] s1_px_ff, s1_py_ff, s1_pz_ff;
   logic signed [15:0]                     s1_aux_ff;
   logic                                   out_valid_ff;
   logic [1:0]                             out_kind_ff;
   logic signed [18:0]                     out_x_ff, out_y_ff, out_z_ff;
   logic signed [15:0]                     out_aux_ff;
   logic                                   adv_out, adv_s1;
   logic signed [7:0]                      fac;

   assign adv_out = !out_valid_ff || rsp_ready;
   assign adv_s1  = !s1_valid_ff || adv_out;
   assign pop     = adv_s1 && !q_stat.empty;
   assign fac     = imusfp_pkg::mul_factor(q_frame.kind);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv_s1) begin
            s1_valid_ff <= !q_stat.empty;
         end
         if (adv_out) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_kind_ff <= q_frame.kind;
         s1_px_ff   <= imusfp_pkg::ProdWidth'(q_frame.raw_x * fac);
         s1_py_ff   <= imusfp_pkg::ProdWidth'(q_frame.raw_y * fac);
         s1_pz_ff   <= imusfp_pkg::ProdWidth'(q_frame.raw_z * fac);
         s1_aux_ff  <= q_frame.aux;
      end
      if (adv_out && s1_valid_ff) begin
         out_kind_ff <= s1_kind_ff;
         out_x_ff    <= imusfp_pkg::scale_down(s1_px_ff, s1_kind_ff);
         out_y_ff    <= imusfp_pkg::scale_down(s1_py_ff, s1_kind_ff);
         out_z_ff    <= imusfp_pkg::scale_down(s1_pz_ff, s1_kind_ff);
         out_aux_ff  <= s1_aux_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_frame_kind = out_kind_ff;
   assign rsp_value_x    = out_x_ff;
   assign rsp_value_y    = out_y_ff;
   assign rsp_value_z    = out_z_ff;
   assign rsp_aux_word   = out_aux_ff;

endmodule
`default_nettype wire

@@ rtl/imu_serial_frame_parser.sv @@
// Sensor byte-stream frame parser. One received byte is taken per clock
// (req_ready stays high unless the two-entry frame queue is full, which only
// happens when the result side stalls). Each byte carries a burst-start flag that
// restarts frame alignment; bytes beyond 33 in one burst are dropped. Every
// eleventh byte closes an 11-byte frame: header 0x55, type 0x51/0x52/0x53 and
// an 8-bit additive checksum must all match, otherwise nothing is emitted.
// A good frame is written into the queue by the edge that takes its last byte,
// then passes through the constant multiplier into the stage-one register and
// through the truncating shift into the result register that drives rsp_valid.
// Results then leave at one per clock while rsp_ready is high.
`default_nettype none
module imu_serial_frame_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [7:0]         req_rx_byte,
   input  wire logic               req_burst_start,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [1:0]         rsp_frame_kind,
   output      logic signed [18:0] rsp_value_x,
   output      logic signed [18:0] rsp_value_y,
   output      logic signed [18:0] rsp_value_z,
   output      logic signed [15:0] rsp_aux_word
);

   imusfp_pkg::queue_ctl_type  q_ctl;
   imusfp_pkg::queue_stat_type q_stat;
   imusfp_pkg::frame_type      wr_frame, rd_frame;
   logic                       push, pop;

   assign q_ctl.push = push;
   assign q_ctl.pop  = pop;

   imusfp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .req_burst_start (req_burst_start),
      .q_stat          (q_stat),
      .push            (push),
      .push_frame      (wr_frame)
   );

   imusfp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctl      (q_ctl),
      .wr_frame (wr_frame),
      .rd_frame (rd_frame),
      .stat     (q_stat)
   );

   imusfp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_stat         (q_stat),
      .q_frame        (rd_frame),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_value_x    (rsp_value_x),
      .rsp_value_y    (rsp_value_y),
      .rsp_value_z    (rsp_value_z),
      .rsp_aux_word   (rsp_aux_word)
   );

endmodule
`default_nettype wire

@@ rtl/imusfp_checker.sv @@
// port-level checks for the frame parser and their binding
`default_nettype none
module imusfp_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [1:0]         rsp_frame_kind,
   input wire logic signed [18:0] rsp_value_x,
   input wire logic signed [15:0] rsp_aux_word
);

   // a result held back by the sink keeps its kind and value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_kind)
                                  && $stable(rsp_value_x))
      else $error("result changed while stalled");

   // nothing comes out right after reset
   a_quiet_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_kind <= imusfp_pkg::KindAngle)
      else $error("unknown frame kind");

   a_rate_aux: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_kind == imusfp_pkg::KindRate |-> rsp_aux_word == 16'sd0)
      else $error("rate frame with nonzero aux word");

   a_x_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_value_x >= -19'sd256000 && rsp_value_x <= 19'sd256000)
      else $error("scaled value out of range");

endmodule

bind imu_serial_frame_parser imusfp_checker u_imusfp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_frame_kind (rsp_frame_kind),
   .rsp_value_x    (rsp_value_x),
   .rsp_aux_word   (rsp_aux_word)
);
`default_nettype wire

@@ tb/imu_serial_frame_parser_tb.sv @@
`timescale 1ns / 1ps
// testbench for the imu serial frame parser: random byte bursts checked against a frame predictor
module imu_serial_frame_parser_tb;

   typedef struct {
      logic [7:0]  rx_byte;
      logic        burst_start;
      int unsigned gap;
      bit          drain;
   } rx_item_type;

   typedef struct {
      logic [1:0]         kind;
      logic signed [18:0] x;
      logic signed [18:0] y;
      logic signed [18:0] z;
      logic signed [15:0] aux;
   } frame_out_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               req_burst_start = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_frame_kind;
   logic signed [18:0] rsp_value_x;
   logic signed [18:0] rsp_value_y;
   logic signed [18:0] rsp_value_z;
   logic signed [15:0] rsp_aux_word;

   rx_item_type   byte_queue[$];
   frame_out_type expected_frames[$];

   // predictor copy of the parser state
   logic [7:0] frame_store[10];
   logic [3:0] frame_pos = '0;
   logic [5:0] burst_used = '0;
   logic [7:0] frame_sum = '0;

   // stimulus generator bookkeeping
   int unsigned gen_burst_len = 0;
   int unsigned gen_live = 0;
   bit          gen_calm = 1'b0;

   int unsigned offered_count = 0;
   int unsigned accepted_count = 0;
   int unsigned idle_left = 0;
   int unsigned rsp_count = 0;
   int unsigned rsp_seen = 0;
   int unsigned stall_left = 0;
   int unsigned long_holds = 0;
   int unsigned dropped_bytes = 0;
   int unsigned kind_count[3] = '{0, 0, 0};
   int unsigned errors = 0;

   imu_serial_frame_parser i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .req_burst_start (req_burst_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_kind  (rsp_frame_kind),
      .rsp_value_x     (rsp_value_x),
      .rsp_value_y     (rsp_value_y),
      .rsp_value_z     (rsp_value_z),
      .rsp_aux_word    (rsp_aux_word)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

   // raw * mul / div with truncation toward zero
   function automatic logic signed [18:0] scale_axis(logic signed [15:0] raw, int mul, int div);
      int prod;
      prod = int'(raw) * mul;
      return 19'(prod / div);
   endfunction

   function automatic logic signed [15:0] stored_word(int lo);
      return $signed({frame_store[lo + 1], frame_store[lo]});
   endfunction

   function automatic void parse_byte(logic [7:0] rx, logic start);
      frame_out_type f;
      logic [7:0] sum_now;
      int         mul;
      int         div;
      if (start) begin
         frame_pos = '0;
         burst_used = '0;
         frame_sum = '0;
      end
      if (burst_used >= imusfp_pkg::MaxBurstBytes) begin
         dropped_bytes++;
         return;
      end
      burst_used++;
      if (frame_pos < imusfp_pkg::FrameLen - 1) begin
         frame_store[frame_pos] = rx;
         frame_sum += rx;
         frame_pos++;
         return;
      end
      // closing byte: checksum compare, then restart alignment
      frame_pos = '0;
      sum_now = frame_sum;
      frame_sum = '0;
      if (frame_store[0] != imusfp_pkg::HdrByte || sum_now != rx) return;
      case (frame_store[1])
         imusfp_pkg::TypeAcc: begin
            f.kind = imusfp_pkg::KindAcc;
            mul = 125;
            div = 16;
         end
         imusfp_pkg::TypeRate: begin
            f.kind = imusfp_pkg::KindRate;
            mul = 125;
            div = 128;
         end
         imusfp_pkg::TypeAngle: begin
            f.kind = imusfp_pkg::KindAngle;
            mul = 45;
            div = 512;
         end
         default: return;
      endcase
      f.x = scale_axis(stored_word(2), mul, div);
      f.y = scale_axis(stored_word(4), mul, div);
      f.z = scale_axis(stored_word(6), mul, div);
      f.aux = (f.kind == imusfp_pkg::KindRate) ? 16'sd0 : stored_word(8);
      expected_frames.push_back(f);
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // result check and input prediction, both on the rising edge
   always @(posedge clock) begin
      frame_out_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_frames.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, got kind %0d x %0d", $time,
                        rsp_frame_kind, rsp_value_x);
            end else begin
               want = expected_frames.pop_front();
               kind_count[want.kind]++;
               check_field("frame_kind", want.kind, rsp_frame_kind);
               check_field("value_x", want.x, rsp_value_x);
               check_field("value_y", want.y, rsp_value_y);
               check_field("value_z", want.z, rsp_value_z);
               check_field("aux_word", want.aux, rsp_aux_word);
            end
         end
         if (req_valid && req_ready) begin
            accepted_count++;
            parse_byte(req_rx_byte, req_burst_start);
         end
      end
   end

   // byte sender
   always @(negedge clock) begin
      rx_item_type it;
      if (!reset && offered_count == accepted_count) begin
         if (idle_left != 0) begin
            idle_left--;
            req_valid <= 1'b0;
         end else if (byte_queue.size() != 0 &&
                      !(byte_queue[0].drain && expected_frames.size() != 0)) begin
            it = byte_queue.pop_front();
            req_rx_byte <= it.rx_byte;
            req_burst_start <= it.burst_start;
            req_valid <= 1'b1;
            idle_left = it.gap;
            offered_count++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver, with two long hold-offs to back up the frame queue
   always @(negedge clock) begin
      if (rsp_count != rsp_seen) begin
         rsp_seen = rsp_count;
         if (rsp_count == 12 || rsp_count == 70) begin
            stall_left = 300;
            long_holds++;
         end else if ((rsp_count / 32) % 3 == 0) begin
            stall_left = 0;
         end else begin
            stall_left = $urandom_range(0, 3);
         end
      end
      rsp_ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
   end

   function automatic void push_byte(logic [7:0] b, logic start, bit drain);
      rx_item_type it;
      if (start) gen_burst_len = 0;
      if (gen_burst_len < imusfp_pkg::MaxBurstBytes) begin
         gen_burst_len++;
         gen_live++;
      end
      it.rx_byte = b;
      it.burst_start = start;
      it.gap = gen_calm ? 0 : $urandom_range(0, 3);
      it.drain = drain;
      byte_queue.push_back(it);
   endfunction

   function automatic void push_frame(logic [7:0] hdr, logic [7:0] type_byte,
                                      logic [15:0] w0, logic [15:0] w1,
                                      logic [15:0] w2, logic [15:0] w3,
                                      bit start, bit bad_sum, int keep_n, bit drain);
      logic [7:0] fb[11];
      logic [7:0] s;
      int         i;
      fb[0] = hdr;
      fb[1] = type_byte;
      {fb[3], fb[2]} = w0;
      {fb[5], fb[4]} = w1;
      {fb[7], fb[6]} = w2;
      {fb[9], fb[8]} = w3;
      s = '0;
      for (i = 0; i < 10; i++) s += fb[i];
      fb[10] = bad_sum ? (s ^ (8'h01 << $urandom_range(0, 7))) : s;
      for (i = 0; i < keep_n; i++) push_byte(fb[i], start && i == 0, drain && i == 0);
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         3: return 16'h0000;
         4: return 16'($urandom_range(0, 31));
         5: return 16'(-$urandom_range(1, 600));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_type();
      int unsigned r;
      logic [7:0]  t;
      r = $urandom_range(0, 99);
      if (r < 30) return imusfp_pkg::TypeAcc;
      if (r < 60) return imusfp_pkg::TypeRate;
      if (r < 90) return imusfp_pkg::TypeAngle;
      t = 8'($urandom);
      if (t >= imusfp_pkg::TypeAcc && t <= imusfp_pkg::TypeAngle) t ^= 8'h04;
      return t;
   endfunction

   function automatic void gen_frame(bit start, int keep_n, bit drain);
      logic [7:0] hdr;
      hdr = imusfp_pkg::HdrByte;
      if ($urandom_range(0, 99) < 5) begin
         hdr = 8'($urandom);
         if (hdr == imusfp_pkg::HdrByte) hdr ^= 8'h80;
      end
      push_frame(hdr, pick_type(), pick_word(), pick_word(), pick_word(), pick_word(),
                 start, $urandom_range(0, 99) < 7, keep_n, drain);
   endfunction

   function automatic void gen_burst(bit force_drain);
      int unsigned r;
      int          n;
      int          i;
      bit          drain;
      bit          first_start;
      gen_calm = ($urandom_range(0, 3) == 0);
      drain = force_drain || ($urandom_range(0, 24) == 0);
      r = $urandom_range(0, 99);
      n = $urandom_range(1, 3);
      // a few bursts carry on without a start flag
      first_start = force_drain || ($urandom_range(0, 19) != 0);
      if (r < 88) begin
         for (i = 0; i < n; i++) gen_frame(i == 0 && first_start, 11, drain && i == 0);
         if (r >= 70 && r < 80) begin
            gen_frame(1'b0, $urandom_range(1, 10), 1'b0);
         end else if (r >= 80) begin
            // fill the burst and run past its limit
            for (i = n; i < 3; i++) gen_frame(1'b0, 11, 1'b0);
            gen_frame(1'b0, $urandom_range(1, 11), 1'b0);
         end
      end else begin
         n = $urandom_range(1, 24);
         for (i = 0; i < n; i++) begin
            push_byte(8'($urandom), (i == 0) || ($urandom_range(0, 7) == 0), drain && i == 0);
         end
      end
   endfunction

   initial begin
      int unsigned live_start;
      // bytes before any burst start, then a start, two full frames and a stray header byte
      gen_calm = 1'b1;
      push_frame(imusfp_pkg::HdrByte, imusfp_pkg::TypeAcc,
                 16'h7FFF, 16'h8000, 16'hFFFF, 16'h8000, 1'b0, 1'b0, 11, 1'b0);
      push_frame(imusfp_pkg::HdrByte, imusfp_pkg::TypeRate,
                 16'h0001, 16'hFF81, 16'h7FFF, 16'h1234, 1'b1, 1'b0, 11, 1'b0);
      push_frame(imusfp_pkg::HdrByte, imusfp_pkg::TypeAngle,
                 16'h8000, 16'h7FFF, 16'hFFF5, 16'h7FFF, 1'b0, 1'b0, 11, 1'b0);
      push_byte(imusfp_pkg::HdrByte, 1'b0, 1'b0);
      live_start = gen_live;
      gen_burst(1'b1);
      while (gen_live - live_start < 1750) gen_burst(1'b0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (byte_queue.size() != 0 || offered_count != accepted_count) @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("sent %0d bytes, %0d of them past a burst limit; %0d frames decoded",
               accepted_count, dropped_bytes, rsp_count);
      $display("accel %0d, rate %0d, angle %0d; result side backed up %0d times",
               kind_count[imusfp_pkg::KindAcc], kind_count[imusfp_pkg::KindRate],
               kind_count[imusfp_pkg::KindAngle], long_holds);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
